### src/nearest_neighbor_image_scaler_defines.svh
// Assertion macros for the nearest neighbour image scaler.
// Included by the modules that carry concurrent checks; depends on nothing else.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define NNS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nns: same-cycle check failed");
// next-cycle implication
`define NNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nns: next-cycle check failed");
`else
`define NNS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NNS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/nns_pkg.sv
// Shared types and codes of the nearest neighbour image scaler.
// No dependencies; imported by every module of the block.
package nns_pkg;

   // item opcodes
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_CELL = 1'b1
   } nns_opcode_type;

   // configuration register indexes
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_PANE_WIDTH   = 3'd2;
   localparam logic [2:0] REG_PANE_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_SCALE_Q16    = 3'd4;
   localparam logic [2:0] REG_STEP_Q16     = 3'd5;
   localparam logic [2:0] REG_PAN_X        = 3'd6;
   localparam logic [2:0] REG_PAN_Y        = 3'd7;

   // configuration register file
   typedef struct packed {
      logic [8:0]  image_width;
      logic [8:0]  image_height;
      logic [10:0] pane_width;
      logic [10:0] pane_height;
      logic [23:0] scale_q16;
      logic [23:0] step_q16;
      logic [15:0] pan_x;
      logic [15:0] pan_y;
   } nns_cfg_type;

   // cell item travelling behind the address pipeline
   typedef struct packed {
      logic       valid;
      logic       hit;
      logic [9:0] cell_x;
      logic [9:0] cell_y;
   } nns_tag_type;

   // pixel store access request
   typedef struct packed {
      logic wr;
      logic rd;
   } nns_mem_ctl_type;

endpackage

### src/nns_addr.sv
// Address pipeline of the scaler: maps a pane cell to a pixel store index.
// Depends on nns_pkg; drives the store request of nns_store.
module nns_addr #(
   parameter  int unsigned MAX_PIXELS     = 65536,
   parameter  int unsigned CELL_ASPECT_Q8 = 512,
   parameter  int unsigned MAX_PANE       = 1024,
   localparam int unsigned AW             = $clog2(MAX_PIXELS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic                     in_opcode,
   input  logic [15:0]              in_pixel_index,
   input  logic [31:0]              in_pixel_rgba,
   input  logic [9:0]               in_cell_x,
   input  logic [9:0]               in_cell_y,
   input  nns_pkg::nns_cfg_type     cfg,
   output nns_pkg::nns_mem_ctl_type mem_ctl,
   output logic [AW-1:0]            mem_addr,
   output logic [31:0]              mem_wdata,
   output nns_pkg::nns_tag_type     tag
);
   import nns_pkg::*;

   localparam int unsigned NSTAGE = 10;
   // reciprocal of the cell aspect: exact floor division for a 25-bit dividend
   localparam int unsigned AL  = $clog2(CELL_ASPECT_Q8);
   localparam int unsigned DK  = 25 + AL;
   localparam longint unsigned DM =
      ((64'd1 << DK) + 64'(CELL_ASPECT_Q8) - 64'd1) / 64'(CELL_ASPECT_Q8);
   localparam logic [26:0] DM_V = 27'(DM);
   localparam logic signed [11:0] ASPECT_V = 12'(CELL_ASPECT_Q8);

   typedef struct packed {
      logic        valid;
      logic        is_cell;
      logic        bad;
      logic [9:0]  cx;
      logic [9:0]  cy;
      logic [15:0] pidx;
      logic [31:0] rgba;
   } item_type;

   function automatic logic [10:0] sat_pane(input logic [10:0] p);
      if ({2'b00, p} > 13'(MAX_PANE)) begin
         return 11'(MAX_PANE);
      end
      return p;
   endfunction

   item_type item_ff [1:NSTAGE];
   item_type item_in [1:NSTAGE];

   logic [10:0] pw;
   logic [10:0] ph;
   logic        disabled;

   logic [32:0] prod_w_ff, prod_w_in;
   logic [32:0] prod_h_ff, prod_h_in;
   logic [16:0] cw_ff, cw_in;
   logic [51:0] hm_ff, hm_in;
   logic [16:0] ch_ff, ch_in;
   logic [9:0]  basex_ff, basex_in;
   logic [9:0]  basey_ff, basey_in;
   logic signed [17:0] dx_ff, dx_in;
   logic signed [17:0] dy_ff, dy_in;
   logic signed [42:0] px_ff, px_in;
   logic signed [29:0] dya_ff, dya_in;
   logic signed [54:0] py_ff, py_in;
   logic [8:0]  ix6_ff, ix6_in;
   logic [8:0]  ix7_ff;
   logic [8:0]  ix8_ff;
   logic [8:0]  ix9_ff;
   logic [8:0]  iy_ff, iy_in;
   logic [17:0] row_ff, row_in;
   logic [18:0] idx_ff, idx_in;
   logic        ix_ok;
   logic        iy_ok;
   logic        idx_ok;
   logic        load_ok;
   logic [16:0] wsum;
   logic [16:0] hsum;
   logic [16:0] xsum;
   logic [16:0] ysum;

   // saturated pane and drawing enable
   assign pw       = sat_pane(cfg.pane_width);
   assign ph       = sat_pane(cfg.pane_height);
   assign disabled = (cfg.image_width == 9'd0) || (cfg.image_height == 9'd0) ||
                     (cfg.scale_q16 == 24'd0);

   // stage 1: take the item, scale the image size
   always_comb begin
      item_in[1].valid   = in_valid;
      item_in[1].is_cell = (in_opcode == OP_CELL);
      item_in[1].bad     = disabled || ({1'b0, in_cell_x} >= pw) || ({1'b0, in_cell_y} >= ph);
      item_in[1].cx      = in_cell_x;
      item_in[1].cy      = in_cell_y;
      item_in[1].pidx    = in_pixel_index;
      item_in[1].rgba    = in_pixel_rgba;
      prod_w_in = 33'(cfg.image_width) * 33'(cfg.scale_q16);
      prod_h_in = 33'(cfg.image_height) * 33'(cfg.scale_q16);
   end

   // stage 2: content width, height divided by the cell aspect
   always_comb begin
      wsum  = prod_w_ff[32:16];
      cw_in = (wsum == 17'd0) ? 17'd1 : wsum;
      hm_in = 52'(prod_h_ff[32:8]) * 52'(DM_V);
   end

   // stage 3: content height, horizontal centring
   always_comb begin
      hsum     = hm_ff[DK+16:DK];
      ch_in    = (hsum == 17'd0) ? 17'd1 : hsum;
      xsum     = {6'd0, pw} - cw_ff;
      basex_in = ({6'd0, pw} > cw_ff) ? 10'(xsum >> 1) : 10'd0;
   end

   // stage 4: vertical centring, column distance from the origin
   always_comb begin
      ysum     = {6'd0, ph} - ch_ff;
      basey_in = ({6'd0, ph} > ch_ff) ? 10'(ysum >> 1) : 10'd0;
      dx_in    = $signed(18'(item_ff[3].cx) + 18'(cfg.pan_x) - 18'(basex_ff));
   end

   // stage 5: row distance, column times step
   always_comb begin
      dy_in = $signed(18'(item_ff[4].cy) + 18'(cfg.pan_y) - 18'(basey_ff));
      px_in = 43'(dx_ff) * 43'($signed({1'b0, cfg.step_q16}));
   end

   // stage 6: source column, truncated toward zero; row times aspect
   always_comb begin
      ix_ok  = 1'b0;
      ix6_in = 9'd0;
      if (!px_ff[42]) begin
         ix_ok  = (px_ff[42:16] < 27'(cfg.image_width));
         ix6_in = 9'(px_ff[42:16]);
      end else if ((&px_ff[42:16]) && (|px_ff[15:0])) begin
         ix_ok = (cfg.image_width != 9'd0);
      end
      dya_in = 30'(dy_ff) * 30'(ASPECT_V);
   end

   // stage 7: row times step
   assign py_in = 55'(dya_ff) * 55'($signed({1'b0, cfg.step_q16}));

   // stage 8: source row, truncated toward zero
   always_comb begin
      iy_ok = 1'b0;
      iy_in = 9'd0;
      if (!py_ff[54]) begin
         iy_ok = (py_ff[54:24] < 31'(cfg.image_height));
         iy_in = 9'(py_ff[54:24]);
      end else if ((&py_ff[54:24]) && (|py_ff[23:0])) begin
         iy_ok = (cfg.image_height != 9'd0);
      end
   end

   // stages 9 and 10: row-major index and store bound
   assign row_in = 18'(iy_ff) * 18'(cfg.image_width);
   assign idx_in = 19'(row_ff) + 19'(ix9_ff);
   assign idx_ok = (21'(idx_in) < 21'(MAX_PIXELS));

   // carry items down the pipe, folding in each range check
   always_comb begin
      for (int s = 2; s <= NSTAGE; s++) begin
         item_in[s] = item_ff[s-1];
      end
      item_in[6].bad  = item_ff[5].bad || !ix_ok;
      item_in[8].bad  = item_ff[7].bad || !iy_ok;
      item_in[10].bad = item_ff[9].bad || !idx_ok;
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      prod_w_ff <= prod_w_in;
      prod_h_ff <= prod_h_in;
      cw_ff     <= cw_in;
      hm_ff     <= hm_in;
      ch_ff     <= ch_in;
      basex_ff  <= basex_in;
      basey_ff  <= basey_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      px_ff     <= px_in;
      dya_ff    <= dya_in;
      py_ff     <= py_in;
      ix6_ff    <= ix6_in;
      ix7_ff    <= ix6_ff;
      ix8_ff    <= ix7_ff;
      ix9_ff    <= ix8_ff;
      iy_ff     <= iy_in;
      row_ff    <= row_in;
      idx_ff    <= idx_in;
      if (reset) begin
         for (int s = 1; s <= NSTAGE; s++) begin
            item_ff[s].valid <= 1'b0;
         end
      end
   end

   // issue the store access: load writes and cell reads share one port
   assign load_ok    = (21'(item_ff[NSTAGE].pidx) < 21'(MAX_PIXELS));
   assign mem_ctl.wr = item_ff[NSTAGE].valid && !item_ff[NSTAGE].is_cell && load_ok;
   assign mem_ctl.rd = item_ff[NSTAGE].valid && item_ff[NSTAGE].is_cell && !item_ff[NSTAGE].bad;
   assign mem_addr   = item_ff[NSTAGE].is_cell ? AW'(idx_ff) : AW'(item_ff[NSTAGE].pidx);
   assign mem_wdata  = item_ff[NSTAGE].rgba;
   assign tag.valid  = item_ff[NSTAGE].valid && item_ff[NSTAGE].is_cell;
   assign tag.hit    = !item_ff[NSTAGE].bad;
   assign tag.cell_x = item_ff[NSTAGE].cx;
   assign tag.cell_y = item_ff[NSTAGE].cy;

endmodule

### src/nns_store.sv
// Pixel store of the scaler: single-port synchronous memory, one access a cycle.
// Depends on nns_pkg and the defines header; fed by nns_addr.
`include "nearest_neighbor_image_scaler_defines.svh"
module nns_store #(
   parameter  int unsigned MAX_PIXELS = 65536,
   localparam int unsigned AW         = $clog2(MAX_PIXELS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  nns_pkg::nns_mem_ctl_type mem_ctl,
   input  logic [AW-1:0]            mem_addr,
   input  logic [31:0]              mem_wdata,
   input  nns_pkg::nns_tag_type     tag_in,
   output logic [31:0]              rd_data,
   output nns_pkg::nns_tag_type     tag_out
);
   import nns_pkg::*;

   logic [31:0] pixel_store [MAX_PIXELS];
   logic [31:0] rdata_ff;
   nns_tag_type tag_ff;

   // write a load, read a cell
   always_ff @(posedge clock) begin
      if (mem_ctl.wr) begin
         pixel_store[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd) begin
         rdata_ff <= pixel_store[mem_addr];
      end
   end

   // hold the tag alongside the read data
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end
   end

   assign rd_data = rdata_ff;
   assign tag_out = tag_ff;

   `NNS_ASSERT_IMPLY(a_one_access, clock, reset, mem_ctl.wr, !mem_ctl.rd)
   `NNS_ASSERT_IMPLY(a_hit_reads, clock, reset, tag_in.valid && tag_in.hit, mem_ctl.rd)
   `NNS_ASSERT_NEXT(a_read_tagged, clock, reset, mem_ctl.rd, tag_out.valid && tag_out.hit)

endmodule

### src/nns_blend.sv
// Alpha composite over black and result register of the scaler.
// Depends on nns_pkg; fed by nns_store.
module nns_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  nns_pkg::nns_tag_type tag_in,
   input  logic [31:0]          pixel,
   output logic                 rsp_valid,
   output logic [9:0]           out_x,
   output logic [9:0]           out_y,
   output logic [7:0]           out_red,
   output logic [7:0]           out_green,
   output logic [7:0]           out_blue,
   output logic                 drawn
);
   import nns_pkg::*;

   // floor(x / 255), exact for x up to 65279
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      logic [16:0] s;
      t = 17'(x) + 17'd1;
      s = t + (t >> 8);
      return 8'(s >> 8);
   endfunction

   nns_tag_type tag_ff;
   logic [15:0] red_ff, red_in;
   logic [15:0] green_ff, green_in;
   logic [15:0] blue_ff, blue_in;
   logic        valid_ff;
   logic [9:0]  x_ff;
   logic [9:0]  y_ff;
   logic [7:0]  ored_ff, ored_in;
   logic [7:0]  ogreen_ff, ogreen_in;
   logic [7:0]  oblue_ff, oblue_in;
   logic        drawn_ff, drawn_in;

   // multiply each channel by alpha
   assign red_in   = 16'(pixel[7:0])   * 16'(pixel[31:24]);
   assign green_in = 16'(pixel[15:8])  * 16'(pixel[31:24]);
   assign blue_in  = 16'(pixel[23:16]) * 16'(pixel[31:24]);

   // divide by full alpha; drop colour on an undrawn cell
   assign drawn_in  = tag_ff.valid && tag_ff.hit;
   assign ored_in   = tag_ff.hit ? div255(red_ff) : 8'd0;
   assign ogreen_in = tag_ff.hit ? div255(green_ff) : 8'd0;
   assign oblue_in  = tag_ff.hit ? div255(blue_ff) : 8'd0;

   always_ff @(posedge clock) begin
      tag_ff    <= tag_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      valid_ff  <= tag_ff.valid;
      x_ff      <= tag_ff.cell_x;
      y_ff      <= tag_ff.cell_y;
      ored_ff   <= ored_in;
      ogreen_ff <= ogreen_in;
      oblue_ff  <= oblue_in;
      drawn_ff  <= drawn_in;
      if (reset) begin
         tag_ff.valid <= 1'b0;
         valid_ff     <= 1'b0;
         drawn_ff     <= 1'b0;
      end
   end

   assign rsp_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_red   = ored_ff;
   assign out_green = ogreen_ff;
   assign out_blue  = oblue_ff;
   assign drawn     = drawn_ff;

endmodule

### src/nearest_neighbor_image_scaler.sv
// Top level of the nearest neighbour image scaler: registers and pipeline.
// Depends on nns_pkg, the defines header, nns_addr, nns_store and nns_blend.
//
// The scaler takes one item every clock and never raises busy. A load item
// (opcode 0) writes one RGBA word into the pixel store and gives no result; a
// cell item (opcode 1) gives one result on the rsp_ ports, strobed by
// rsp_valid, in acceptance order. On its way the item passes through the
// address pipeline (scaling, centring and the two step multiplies, each
// registered), the store read register and the product and result registers of
// nns_blend. Loads and cell reads use the single store port at the same
// pipeline stage, so a cell always sees every load accepted before it and
// none after it. The store has no reset and no clearing pass: read only
// entries that have been loaded. Write the csr_ registers only while no cell
// item is in flight. There is no back-pressure; the receiver must take each
// result in the cycle it is shown.
`include "nearest_neighbor_image_scaler_defines.svh"
module nearest_neighbor_image_scaler #(
   parameter int unsigned MAX_PIXELS     = 65536,
   parameter int unsigned CELL_ASPECT_Q8 = 512,
   parameter int unsigned MAX_PANE       = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [15:0] req_pixel_index,
   input  logic [31:0] req_pixel_rgba,
   input  logic [9:0]  req_cell_x,
   input  logic [9:0]  req_cell_y,
   output logic        rsp_valid,
   output logic [9:0]  rsp_out_x,
   output logic [9:0]  rsp_out_y,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_drawn,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import nns_pkg::*;

   localparam int unsigned AW      = $clog2(MAX_PIXELS);
   localparam int unsigned LATENCY = 13;

   nns_cfg_type     cfg_ff, cfg_in;
   nns_mem_ctl_type mem_ctl;
   logic [AW-1:0]   mem_addr;
   logic [31:0]     mem_wdata;
   nns_tag_type     addr_tag;
   nns_tag_type     store_tag;
   logic [31:0]     rd_data;
   logic            accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[8:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[8:0];
            REG_PANE_WIDTH:   cfg_in.pane_width   = csr_wdata[10:0];
            REG_PANE_HEIGHT:  cfg_in.pane_height  = csr_wdata[10:0];
            REG_SCALE_Q16:    cfg_in.scale_q16    = csr_wdata;
            REG_STEP_Q16:     cfg_in.step_q16     = csr_wdata;
            REG_PAN_X:        cfg_in.pan_x        = csr_wdata[15:0];
            REG_PAN_Y:        cfg_in.pan_y        = csr_wdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 9'd0;
         cfg_ff.image_height <= 9'd0;
         cfg_ff.pane_width   <= 11'd1;
         cfg_ff.pane_height  <= 11'd1;
         cfg_ff.scale_q16    <= 24'd65536;
         cfg_ff.step_q16     <= 24'd65536;
         cfg_ff.pan_x        <= 16'd0;
         cfg_ff.pan_y        <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // cell to store index
   nns_addr #(
      .MAX_PIXELS     (MAX_PIXELS),
      .CELL_ASPECT_Q8 (CELL_ASPECT_Q8),
      .MAX_PANE       (MAX_PANE)
   ) u_addr (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .in_opcode      (req_opcode),
      .in_pixel_index (req_pixel_index),
      .in_pixel_rgba  (req_pixel_rgba),
      .in_cell_x      (req_cell_x),
      .in_cell_y      (req_cell_y),
      .cfg            (cfg_ff),
      .mem_ctl        (mem_ctl),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .tag            (addr_tag)
   );

   // pixel store
   nns_store #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .tag_in    (addr_tag),
      .rd_data   (rd_data),
      .tag_out   (store_tag)
   );

   // composite and present
   nns_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (store_tag),
      .pixel     (rd_data),
      .rsp_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_red   (rsp_out_red),
      .out_green (rsp_out_green),
      .out_blue  (rsp_out_blue),
      .drawn     (rsp_drawn)
   );

   `NNS_ASSERT_IMPLY(a_result_origin, clock, reset, rsp_valid, $past(start, LATENCY) && ($past(req_opcode, LATENCY) == OP_CELL) && (rsp_out_x == $past(req_cell_x, LATENCY)) && (rsp_out_y == $past(req_cell_y, LATENCY)))
   `NNS_ASSERT_IMPLY(a_undrawn_black, clock, reset, rsp_valid && !rsp_drawn, (rsp_out_red == 8'd0) && (rsp_out_green == 8'd0) && (rsp_out_blue == 8'd0))
   `NNS_ASSERT_IMPLY(a_drawn_strobed, clock, reset, rsp_drawn, rsp_valid)

endmodule

### sim/tb_nearest_neighbor_image_scaler.sv
`timescale 1ns / 100ps
// Self-checking bench for the nearest neighbour image scaler: directed table, then random phases.
// Depends on nns_pkg and the nearest_neighbor_image_scaler top level only.
module tb_nearest_neighbor_image_scaler;
   import nns_pkg::*;

   localparam int unsigned MAX_PIXELS     = 65536;
   localparam int unsigned CELL_ASPECT_Q8 = 512;
   localparam int unsigned MAX_PANE       = 1024;
   localparam int          CLOCK_PERIOD   = 20;
   localparam int          RESET_CYCLES   = 5;
   localparam int          PIPE_LATENCY   = 12;
   localparam int          NUM_PHASES     = 12;
   localparam int          ITEMS_PER_PHASE = 36;
   localparam int unsigned LIMIT_CYCLES   = 200000;

   // one result of a cell item, as shown on the rsp_ ports
   typedef struct packed {
      logic [9:0] x;
      logic [9:0] y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       drawn;
   } pane_result_t;

   // directed table: an item, or a register write done once the pipeline is empty
   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_t;

   typedef struct packed {
      row_kind_t      kind;
      nns_opcode_type opcode;
      logic [15:0]    index;    // pixel index, or register index
      logic [31:0]    data;     // pixel word, or register value
      logic [9:0]     cell_x;
      logic [9:0]     cell_y;
      logic           literal;  // use the colour and drawn below instead of predicting
      logic [23:0]    colour;   // {red, green, blue}
      logic           drawn;
   } directed_row_t;

   localparam int NUM_DIRECTED = 41;
   localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
      // after reset drawing is disabled
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd0, 10'd0, 1'b1, 24'h000000, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd1023, 10'd1023, 1'b1, 24'h000000, 1'b0},
      // 4x4 image at twice the size, centred in a 16x8 pane
      '{ROW_CSR, OP_LOAD, 16'(REG_IMAGE_WIDTH), 32'd4, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_IMAGE_HEIGHT), 32'd4, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_PANE_WIDTH), 32'd16, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_PANE_HEIGHT), 32'd8, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_SCALE_Q16), 32'h2_0000, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_STEP_Q16), 32'h8000, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_LOAD, 16'd0, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_LOAD, 16'd1, 32'h00FF_FFFF, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_LOAD, 16'd5, 32'h8040_2010, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      // image origin: opaque white; next source column: transparent, drawn black
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd4, 10'd2, 1'b1, 24'hFFFFFF, 1'b1},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd6, 10'd2, 1'b1, 24'h000000, 1'b1},
      // small negative distances, half alpha, far pane corner
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd3, 10'd2, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd3, 10'd1, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd6, 10'd3, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd15, 10'd7, 1'b0, 24'h0, 1'b0},
      // just outside the pane
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd16, 10'd0, 1'b1, 24'h000000, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd0, 10'd8, 1'b1, 24'h000000, 1'b0},
      // zero step pins every cell to the image origin
      '{ROW_CSR, OP_LOAD, 16'(REG_STEP_Q16), 32'd0, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd15, 10'd7, 1'b1, 24'hFFFFFF, 1'b1},
      // zero scale disables drawing
      '{ROW_CSR, OP_LOAD, 16'(REG_SCALE_Q16), 32'd0, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd4, 10'd2, 1'b1, 24'h000000, 1'b0},
      // largest scale, full 256x256 image, oversized pane
      '{ROW_CSR, OP_LOAD, 16'(REG_SCALE_Q16), 32'hFF_FFFF, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_STEP_Q16), 32'h8000, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_IMAGE_WIDTH), 32'd256, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_IMAGE_HEIGHT), 32'd256, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_PANE_WIDTH), 32'd2047, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_PANE_HEIGHT), 32'd2047, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_LOAD, 16'hFFFF, 32'hFF00_FF00, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd1023, 10'd1023, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd510, 10'd255, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd511, 10'd256, 1'b0, 24'h0, 1'b0},
      // largest pan pushes the image out of view
      '{ROW_CSR, OP_LOAD, 16'(REG_PAN_X), 32'hFFFF, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_PAN_Y), 32'hFFFF, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      // 511x511 image: row-major index runs past the store
      '{ROW_CSR, OP_LOAD, 16'(REG_IMAGE_WIDTH), 32'd511, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_IMAGE_HEIGHT), 32'd511, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_PAN_X), 32'd0, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_CSR, OP_LOAD, 16'(REG_PAN_Y), 32'd0, 10'd0, 10'd0, 1'b0, 24'h0, 1'b0},
      '{ROW_ITEM, OP_CELL, 16'd0, 32'd0, 10'd1000, 10'd300, 1'b0, 24'h0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [15:0] req_pixel_index;
   logic [31:0] req_pixel_rgba;
   logic [9:0]  req_cell_x;
   logic [9:0]  req_cell_y;
   logic        rsp_valid;
   logic [9:0]  rsp_out_x;
   logic [9:0]  rsp_out_y;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        rsp_drawn;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   // predictor state: register copy, loaded pixels and results still owed
   nns_cfg_type  scaler_cfg;
   logic [31:0]  loaded_pixels [int unsigned];
   pane_result_t expected_cells [$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  burst_left = 0;

   nearest_neighbor_image_scaler #(
      .MAX_PIXELS     (MAX_PIXELS),
      .CELL_ASPECT_Q8 (CELL_ASPECT_Q8),
      .MAX_PANE       (MAX_PANE)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_pixel_index (req_pixel_index),
      .req_pixel_rgba  (req_pixel_rgba),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_drawn       (rsp_drawn),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Map a pane cell to a store index; returns 0 when the cell stays undrawn.
   function automatic bit locate_pixel(input logic [9:0] cx, input logic [9:0] cy,
                                       output int unsigned store_idx);
      longint iw, ih, sc, st, pw, ph, cw, ch, ox, oy, ix, iy, idx, col, row;
      iw = scaler_cfg.image_width;
      ih = scaler_cfg.image_height;
      sc = scaler_cfg.scale_q16;
      st = scaler_cfg.step_q16;
      pw = scaler_cfg.pane_width;
      ph = scaler_cfg.pane_height;
      col = cx;
      row = cy;
      store_idx = 0;
      if (iw == 0 || ih == 0 || sc == 0) return 1'b0;
      // clip the pane to the largest the block supports
      if (pw > MAX_PANE) pw = MAX_PANE;
      if (ph > MAX_PANE) ph = MAX_PANE;
      if (col >= pw || row >= ph) return 1'b0;
      // scaled content size, the vertical one squashed by the cell aspect
      cw = (iw * sc) / 65536;
      if (cw < 1) cw = 1;
      ch = (ih * sc * 256) / (longint'(CELL_ASPECT_Q8) * 65536);
      if (ch < 1) ch = 1;
      // centre when smaller than the pane, then shift by the pan
      ox = ((pw > cw) ? (pw - cw) / 2 : 0) - longint'(scaler_cfg.pan_x);
      oy = ((ph > ch) ? (ph - ch) / 2 : 0) - longint'(scaler_cfg.pan_y);
      // signed division truncates toward zero
      iy = (row - oy) * longint'(CELL_ASPECT_Q8) * st / 64'sd16777216;
      if (iy < 0 || iy >= ih) return 1'b0;
      ix = (col - ox) * st / 64'sd65536;
      if (ix < 0 || ix >= iw) return 1'b0;
      idx = iy * iw + ix;
      if (idx >= MAX_PIXELS) return 1'b0;
      store_idx = int'(idx);
      return 1'b1;
   endfunction

   function automatic logic [7:0] over_black(input logic [7:0] channel, input logic [7:0] alpha);
      int unsigned product;
      product = channel;
      product = product * alpha;
      return 8'(product / 255);
   endfunction

   // Expected result of a cell item against the current store contents.
   function automatic pane_result_t shade_cell(input logic [9:0] cx, input logic [9:0] cy);
      pane_result_t res;
      int unsigned  store_idx;
      logic [31:0]  pixel;
      res = '{cx, cy, 8'd0, 8'd0, 8'd0, 1'b0};
      if (locate_pixel(cx, cy, store_idx)) begin
         pixel = loaded_pixels.exists(store_idx) ? loaded_pixels[store_idx] : 32'd0;
         res.red   = over_black(pixel[7:0], pixel[31:24]);
         res.green = over_black(pixel[15:8], pixel[31:24]);
         res.blue  = over_black(pixel[23:16], pixel[31:24]);
         res.drawn = 1'b1;
      end
      return res;
   endfunction

   function automatic logic [31:0] random_rgba();
      logic [31:0] word;
      word = $urandom;
      case ($urandom_range(0, 7))
         0, 1: word[31:24] = 8'hFF;
         2:    word[31:24] = 8'h00;
         default: ;
      endcase
      return word;
   endfunction

   function automatic logic [10:0] pick_image_size();
      case ($urandom_range(0, 11))
         0:       return 11'd0;
         1:       return 11'd256;
         2:       return 11'd511;
         3:       return 11'($urandom_range(1, 511));
         default: return 11'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [10:0] pick_pane_size();
      case ($urandom_range(0, 11))
         0:       return 11'd0;
         1:       return 11'd1024;
         2:       return 11'd2047;
         3:       return 11'd1;
         default: return 11'($urandom_range(2, 40));
      endcase
   endfunction

   // Mostly inside the pane and one beyond its edge, now and then anywhere.
   function automatic logic [9:0] pick_coord(input logic [10:0] span);
      if (span == 0 || $urandom_range(0, 5) == 0) return 10'($urandom_range(0, 1023));
      return 10'($urandom_range(0, (span > 1023) ? 1023 : span));
   endfunction

   task automatic report_mismatch(input string text);
      mismatch_count++;
      $display("cycle %0d: mismatch: %s", cycle_count, text);
   endtask

   // Drive one item in the current burst and record its effect once accepted.
   task automatic push_item(input nns_opcode_type op, input logic [15:0] pidx,
                            input logic [31:0] rgba, input logic [9:0] cx, input logic [9:0] cy,
                            input bit use_literal, input pane_result_t literal_result);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start           <= 1'b1;
      req_opcode      <= op;
      req_pixel_index <= pidx;
      req_pixel_rgba  <= rgba;
      req_cell_x      <= cx;
      req_cell_y      <= cy;
      do @(posedge clock); while (busy);
      if (op == OP_LOAD) begin
         loaded_pixels[pidx] = rgba;
      end else begin
         expected_cells.push_back(use_literal ? literal_result : shade_cell(cx, cy));
      end
   endtask

   // Request a cell, loading its source pixel first if it has never been written.
   task automatic send_cell(input logic [9:0] cx, input logic [9:0] cy,
                            input bit use_literal, input pane_result_t literal_result);
      int unsigned store_idx;
      if (locate_pixel(cx, cy, store_idx) && !loaded_pixels.exists(store_idx)) begin
         push_item(OP_LOAD, 16'(store_idx), random_rgba(), 10'($urandom), 10'($urandom),
                   1'b0, '0);
      end
      push_item(OP_CELL, 16'($urandom), $urandom, cx, cy, use_literal, literal_result);
   endtask

   // Hold off the sender until every result has come and the pipeline is empty.
   task automatic drain_pipeline();
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [23:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  scaler_cfg.image_width  = value[8:0];
         REG_IMAGE_HEIGHT: scaler_cfg.image_height = value[8:0];
         REG_PANE_WIDTH:   scaler_cfg.pane_width   = value[10:0];
         REG_PANE_HEIGHT:  scaler_cfg.pane_height  = value[10:0];
         REG_SCALE_Q16:    scaler_cfg.scale_q16    = value;
         REG_STEP_Q16:     scaler_cfg.step_q16     = value;
         REG_PAN_X:        scaler_cfg.pan_x        = value[15:0];
         REG_PAN_Y:        scaler_cfg.pan_y        = value[15:0];
         default: ;
      endcase
   endtask

   // Drain, then rewrite every register; step mostly follows the scale.
   task automatic write_random_setup();
      logic [23:0] scale;
      logic [23:0] step;
      logic [2:0]  pan_idx;
      logic [15:0] pan;
      drain_pipeline();
      write_register(REG_IMAGE_WIDTH, 24'(pick_image_size()));
      write_register(REG_IMAGE_HEIGHT, 24'(pick_image_size()));
      write_register(REG_PANE_WIDTH, 24'(pick_pane_size()));
      write_register(REG_PANE_HEIGHT, 24'(pick_pane_size()));
      case ($urandom_range(0, 9))
         0:       scale = 24'd0;
         1:       scale = 24'hFF_FFFF;
         default: scale = 24'($urandom_range(32'h4000, 32'h6_0000));
      endcase
      write_register(REG_SCALE_Q16, scale);
      case ($urandom_range(0, 9))
         0:       step = 24'd0;
         1:       step = 24'hFF_FFFF;
         2:       step = 24'($urandom);
         default: step = (scale == 0) ? 24'h1_0000 : 24'(64'h1_0000_0000 / scale);
      endcase
      write_register(REG_STEP_Q16, step);
      for (pan_idx = REG_PAN_X; ; pan_idx++) begin
         case ($urandom_range(0, 9))
            6, 7:    pan = 16'($urandom_range(0, 6));
            8:       pan = 16'hFFFF;
            9:       pan = 16'($urandom);
            default: pan = 16'd0;
         endcase
         write_register(pan_idx, 24'(pan));
         if (pan_idx == REG_PAN_Y) break;
      end
   endtask

   // Check each strobed result against the oldest expectation.
   always @(posedge clock) begin : watch_results
      pane_result_t seen;
      pane_result_t want;
      if (!reset && rsp_valid) begin
         seen = '{rsp_out_x, rsp_out_y, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_drawn};
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected result for cell (%0d,%0d)", seen.x, seen.y));
         end else begin
            want = expected_cells.pop_front();
            if (seen !== want) begin
               report_mismatch($sformatf(
                  "cell (%0d,%0d) rgb %h %h %h drawn %b, wanted (%0d,%0d) rgb %h %h %h drawn %b",
                  seen.x, seen.y, seen.red, seen.green, seen.blue, seen.drawn,
                  want.x, want.y, want.red, want.green, want.blue, want.drawn));
            end
         end
      end
   end

   // Stop a hung run.
   initial begin : watchdog
      wait (cycle_count >= LIMIT_CYCLES);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      directed_row_t row;
      pane_result_t  literal_result;
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = OP_LOAD;
      req_pixel_index = '0;
      req_pixel_rgba  = '0;
      req_cell_x      = '0;
      req_cell_y      = '0;
      csr_write       = 1'b0;
      csr_index       = REG_IMAGE_WIDTH;
      csr_wdata       = '0;
      scaler_cfg      = '{9'd0, 9'd0, 11'd1, 11'd1, 24'h1_0000, 24'h1_0000, 16'd0, 16'd0};

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (DIRECTED_ROWS[r]) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_CSR) begin
            drain_pipeline();
            write_register(row.index[2:0], row.data[23:0]);
         end else if (row.opcode == OP_LOAD) begin
            push_item(OP_LOAD, row.index, row.data, row.cell_x, row.cell_y, 1'b0, '0);
         end else begin
            literal_result = '{row.cell_x, row.cell_y, row.colour[23:16], row.colour[15:8],
                               row.colour[7:0], row.drawn};
            send_cell(row.cell_x, row.cell_y, row.literal, literal_result);
         end
      end

      // random phases: fresh settings, then a mix of loads and cell requests
      repeat (NUM_PHASES) begin
         write_random_setup();
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 3) begin
               if (scaler_cfg.image_width * scaler_cfg.image_height != 0 &&
                   $urandom_range(0, 9) < 7) begin
                  push_item(OP_LOAD, 16'($urandom_range(0,
                               (scaler_cfg.image_width * scaler_cfg.image_height > MAX_PIXELS)
                               ? MAX_PIXELS - 1
                               : scaler_cfg.image_width * scaler_cfg.image_height - 1)),
                            random_rgba(), 10'($urandom), 10'($urandom), 1'b0, '0);
               end else begin
                  push_item(OP_LOAD, 16'($urandom), random_rgba(), 10'($urandom),
                            10'($urandom), 1'b0, '0);
               end
            end else begin
               send_cell(pick_coord(scaler_cfg.pane_width), pick_coord(scaler_cfg.pane_height),
                         1'b0, '0);
            end
         end
      end

      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/nns_pkg.sv
src/nns_addr.sv
src/nns_store.sv
src/nns_blend.sv
src/nearest_neighbor_image_scaler.sv
sim/tb_nearest_neighbor_image_scaler.sv
